@@ hdl/bearing_pair_moment_accumulator_core_macros.svh @@
// Assertion macros shared by the bearing pair moment accumulator RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef BEARING_PAIR_MOMENT_ACCUMULATOR_CORE_MACROS_SVH
`define BEARING_PAIR_MOMENT_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPMA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPMA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bpma_pkg.sv @@
// Shared types, constants and index tables for the bearing pair moment accumulator.
// No dependencies.
package bpma_pkg;

  localparam int COORD_W     = 16;
  localparam int BEAR_W      = 17;
  localparam int MAG_W       = 16;
  localparam int SQ_W        = 32;
  localparam int RAD_W       = 56;
  localparam int ROOT_W      = 28;
  localparam int NUM_W       = 43;
  localparam int QUO_W       = 20;
  localparam int DIV_CNT_W   = 5;
  localparam int Z_COMPONENT = 4096;
  localparam int BEAR_ONE    = 32768;

  localparam int WEIGHT_W    = 32;
  localparam int PROD_W      = 62;
  localparam int SUM_WIDTH   = 48;
  localparam int ENTRY_W     = 48;
  localparam int MAX_PAIRS   = 4096;
  localparam int COUNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int PAIR_OUT_W  = 13;
  localparam int N_TERMS     = 6;
  localparam int N_ENTRIES   = 6;
  localparam int N_SUMS      = N_TERMS * N_ENTRIES;
  localparam int ADDR_W      = $clog2(N_SUMS);
  localparam int IDX_W       = 3;
  localparam logic [IDX_W-1:0] LAST_TERM  = IDX_W'(N_TERMS - 1);
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(N_ENTRIES - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [BEAR_W-1:0] bear_t;
  typedef bear_t [2:0] bear_vec_t;

  typedef struct packed {
    bear_vec_t f1;
    bear_vec_t f2;
    logic      final_pair;
  } pair_item_t;

  typedef enum logic [2:0] {
    L_IDLE, L_SQR, L_ROOT, L_PREP, L_DIV, L_DONE
  } lift_state_t;

  typedef enum logic [1:0] {
    F_IDLE, F_RUN, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ACC, B_DRAIN, B_GATHER, B_SHOW
  } back_state_t;

  // Weight component selectors per term: xx, yy, zz, xy, yz, zx.
  function automatic logic [1:0] weight_a(input logic [IDX_W-1:0] t);
    logic [1:0] s;
    unique case (t)
      3'd0, 3'd3: s = 2'd0;
      3'd1, 3'd4: s = 2'd1;
      default:    s = 2'd2;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] weight_b(input logic [IDX_W-1:0] t);
    logic [1:0] s;
    unique case (t)
      3'd0, 3'd5: s = 2'd0;
      3'd1, 3'd3: s = 2'd1;
      default:    s = 2'd2;
    endcase
    return s;
  endfunction

  // Row and column of each upper-triangle entry: 00, 01, 02, 11, 12, 22.
  function automatic logic [1:0] entry_row(input logic [IDX_W-1:0] e);
    logic [1:0] s;
    unique case (e)
      3'd0, 3'd1, 3'd2: s = 2'd0;
      3'd3, 3'd4:       s = 2'd1;
      default:          s = 2'd2;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] entry_col(input logic [IDX_W-1:0] e);
    logic [1:0] s;
    unique case (e)
      3'd0:       s = 2'd0;
      3'd1, 3'd3: s = 2'd1;
      default:    s = 2'd2;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/bearing_pair_moment_accumulator_core.sv @@
// Top level of the bearing pair moment accumulator: front end, pair queue and
// back end. Depends on bpma_pkg, bpma_front, bpma_queue and bpma_back.
//
//   Channel | Ports                                   | Handshake
//   input   | in_ref_x/y, in_cur_x/y, in_final_pair   | push / full
//   result  | out_term_index, out_entry_*, out_pair_* | empty / pop
//
// full stays high after each accepted pair until the pair enters the queue; this covers
// the 28-step square root, the 20-step dividers and the control states in each lift unit,
// and both points run at once. The back end takes each pair from the queue, runs its 36
// products through its single 32x32 multiplier and drains the pipeline. After a final pair
// each of the six results is gathered from the sum memory and held on the result ports.
// Reset is synchronous and clears all sums and the pair count.
// A two-entry queue lets the front keep working while results wait to be popped.
module bearing_pair_moment_accumulator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [bpma_pkg::COORD_W-1:0]  in_ref_x,
  input  logic signed [bpma_pkg::COORD_W-1:0]  in_ref_y,
  input  logic signed [bpma_pkg::COORD_W-1:0]  in_cur_x,
  input  logic signed [bpma_pkg::COORD_W-1:0]  in_cur_y,
  input  logic                                 in_final_pair,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [bpma_pkg::IDX_W-1:0]           out_term_index,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  out_entry_00,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  out_entry_01,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  out_entry_02,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  out_entry_11,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  out_entry_12,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  out_entry_22,
  output logic [bpma_pkg::PAIR_OUT_W-1:0]      out_pair_count,
  output logic                                 out_final_term
);
  import bpma_pkg::*;

  logic       q_push, q_full, q_pop, q_empty;
  pair_item_t q_wr_item, q_rd_item;

  bpma_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .ref_x(in_ref_x), .ref_y(in_ref_y), .cur_x(in_cur_x), .cur_y(in_cur_y),
    .final_pair(in_final_pair),
    .q_push(q_push), .q_full(q_full), .q_item(q_wr_item)
  );

  bpma_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(q_push), .wr_item(q_wr_item), .q_full(q_full),
    .rd_en(q_pop), .rd_item(q_rd_item), .q_empty(q_empty)
  );

  bpma_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_item(q_rd_item), .q_empty(q_empty), .q_pop(q_pop),
    .empty(empty), .pop(pop),
    .term_index(out_term_index),
    .entry_00(out_entry_00), .entry_01(out_entry_01), .entry_02(out_entry_02),
    .entry_11(out_entry_11), .entry_12(out_entry_12), .entry_22(out_entry_22),
    .pair_count(out_pair_count), .final_term(out_final_term)
  );

endmodule

@@ hdl/bpma_lift.sv @@
// Lifts one Q4.12 point to a Q1.15 unit bearing: bit-serial square root, then
// three restoring dividers in parallel. Depends on bpma_pkg.
module bpma_lift (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [bpma_pkg::COORD_W-1:0]   x,
  input  logic signed [bpma_pkg::COORD_W-1:0]   y,
  output logic                                  done,
  output bpma_pkg::bear_vec_t                   bear
);
  import bpma_pkg::*;

  lift_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] x_r, y_r;
  logic [2:0][MAG_W-1:0]     mag_r;
  logic [2:0]                neg_r;
  logic [RAD_W-1:0]          v_r, root_r, bit_r;
  logic [ROOT_W-1:0]         r_r;
  logic [2:0][ROOT_W-1:0]    rem_r;
  logic [2:0][QUO_W-1:0]     lo_r, q_r;
  logic [DIV_CNT_W-1:0]      cnt_r;

  logic signed [SQ_W-1:0]    xx, yy;
  logic [SQ_W-1:0]           sq_len;
  logic [RAD_W-1:0]          root_sum;

  assign xx       = x_r * x_r;
  assign yy       = y_r * y_r;
  assign sq_len   = $unsigned(xx) + $unsigned(yy) + (SQ_W'(1) << 24);
  assign root_sum = root_r + bit_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: if (start) state_nxt = L_SQR;
      L_SQR:  state_nxt = L_ROOT;
      L_ROOT: if (bit_r[0]) state_nxt = L_PREP;
      L_PREP: state_nxt = L_DIV;
      L_DIV:  if (cnt_r == DIV_CNT_W'(QUO_W - 1)) state_nxt = L_DONE;
      L_DONE: state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    logic [BEAR_W-1:0] m;
    done = (state_r == L_DONE);
    for (int i = 0; i < 3; i++) begin
      m = (q_r[i] > QUO_W'(BEAR_ONE)) ? BEAR_W'(BEAR_ONE) : q_r[i][BEAR_W-1:0];
      bear[i] = neg_r[i] ? -$signed(m) : $signed(m);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0]  num;
    logic [ROOT_W:0]   tr;
    logic              ge;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          x_r      <= x;
          y_r      <= y;
          mag_r[0] <= x[COORD_W-1] ? MAG_W'(-x) : MAG_W'(x);
          mag_r[1] <= y[COORD_W-1] ? MAG_W'(-y) : MAG_W'(y);
          mag_r[2] <= MAG_W'(Z_COMPONENT);
          neg_r    <= {1'b0, y[COORD_W-1], x[COORD_W-1]};
        end
      end
      L_SQR: begin
        v_r    <= {sq_len, 24'd0};
        root_r <= '0;
        bit_r  <= RAD_W'(1) << (RAD_W - 2);
      end
      L_ROOT: begin
        if (v_r >= root_sum) begin
          v_r    <= v_r - root_sum;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      L_PREP: begin
        r_r   <= root_r[ROOT_W-1:0];
        cnt_r <= '0;
        for (int i = 0; i < 3; i++) begin
          num      = {mag_r[i], 27'd0} + NUM_W'(root_r[ROOT_W-1:1]);
          rem_r[i] <= ROOT_W'(num[NUM_W-1:QUO_W]);
          lo_r[i]  <= num[QUO_W-1:0];
          q_r[i]   <= '0;
        end
      end
      L_DIV: begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        for (int i = 0; i < 3; i++) begin
          tr = {rem_r[i], lo_r[i][QUO_W-1]};
          ge = (tr >= {1'b0, r_r});
          rem_r[i] <= ge ? ROOT_W'(tr - {1'b0, r_r}) : tr[ROOT_W-1:0];
          lo_r[i]  <= {lo_r[i][QUO_W-2:0], 1'b0};
          q_r[i]   <= {q_r[i][QUO_W-2:0], ge};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/bpma_front.sv @@
// Front end: accepts a point pair, lifts both points to bearings and hands
// the pair to the queue. Depends on bpma_pkg and bpma_lift.
module bpma_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [bpma_pkg::COORD_W-1:0]  ref_x,
  input  logic signed [bpma_pkg::COORD_W-1:0]  ref_y,
  input  logic signed [bpma_pkg::COORD_W-1:0]  cur_x,
  input  logic signed [bpma_pkg::COORD_W-1:0]  cur_y,
  input  logic                                 final_pair,
  output logic                                 q_push,
  input  logic                                 q_full,
  output bpma_pkg::pair_item_t                 q_item
);
  import bpma_pkg::*;

  front_state_t state_r, state_nxt;
  logic         final_r;
  logic         start, done_ref, done_cur;
  bear_vec_t    bear_ref, bear_cur;

  bpma_lift u_lift_ref (
    .clk(clk), .rst_n(rst_n), .start(start), .x(ref_x), .y(ref_y),
    .done(done_ref), .bear(bear_ref)
  );

  bpma_lift u_lift_cur (
    .clk(clk), .rst_n(rst_n), .start(start), .x(cur_x), .y(cur_y),
    .done(done_cur), .bear(bear_cur)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (push) state_nxt = F_RUN;
      F_RUN:   if (done_ref && done_cur) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state_r != F_IDLE);
    start  = (state_r == F_IDLE) && push;
    q_push = (state_r == F_PUSH) && !q_full;
    q_item = '{f1: bear_ref, f2: bear_cur, final_pair: final_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      final_r <= final_pair;
    end
  end

endmodule

@@ hdl/bpma_queue.sv @@
// Short queue of lifted bearing pairs between the front and back ends.
// Depends on bpma_pkg.
module bpma_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  bpma_pkg::pair_item_t  wr_item,
  output logic                  q_full,
  input  logic                  rd_en,
  output bpma_pkg::pair_item_t  rd_item,
  output logic                  q_empty
);
  import bpma_pkg::*;

  pair_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (rd_en) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ hdl/bpma_back.sv @@
// Back end: weights the outer product of each bearing pair into 36 saturating
// sums held in a small memory and reads them out per term. Depends on bpma_pkg.
`include "bearing_pair_moment_accumulator_core_macros.svh"
module bpma_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bpma_pkg::pair_item_t                 q_item,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [bpma_pkg::IDX_W-1:0]           term_index,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  entry_00,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  entry_01,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  entry_02,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  entry_11,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  entry_12,
  output logic signed [bpma_pkg::ENTRY_W-1:0]  entry_22,
  output logic [bpma_pkg::PAIR_OUT_W-1:0]      pair_count,
  output logic                                 final_term
);
  import bpma_pkg::*;

  back_state_t state_r, state_nxt;
  pair_item_t  item_r;
  logic [IDX_W-1:0] t_r, e_r, k_r, g_r;
  logic [COUNT_W-1:0] pairs_r;

  logic signed [WEIGHT_W-1:0]  w1_r, fe1_r;
  logic [ADDR_W-1:0]           a1_r, a2_r, a3_r;
  logic                        v1_r, v2_r, v3_r;
  logic signed [PROD_W-1:0]    p2_r;
  logic signed [WEIGHT_W-1:0]  c3_r;
  logic signed [SUM_WIDTH-1:0] acc3_r, rd_r;
  logic                        rdv_r;

  logic signed [SUM_WIDTH-1:0] sum_mem_r [N_SUMS];
  logic [N_SUMS-1:0]           valid_r;
  logic signed [ENTRY_W-1:0]   out_entry_r [N_ENTRIES];

  logic                        acc_step, acc_last, pipe_busy, gathering;
  logic [ADDR_W-1:0]           acc_addr, gather_addr, rd_addr;
  logic signed [2*BEAR_W-1:0]  w_full, fe_full;
  logic signed [2*WEIGHT_W-1:0] p_full;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_sat;

  // Q4.60 to Q2.30, rounding half away from zero.
  function automatic logic signed [WEIGHT_W-1:0] round30(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0]   mag;
    logic [WEIGHT_W-1:0] q;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    q   = WEIGHT_W'((mag + (PROD_W'(1) << 29)) >> 30);
    return p[PROD_W-1] ? -$signed(q) : $signed(q);
  endfunction

  assign acc_step    = (state_r == B_ACC);
  assign acc_last    = (t_r == LAST_TERM) && (e_r == LAST_ENTRY);
  assign pipe_busy   = v1_r || v2_r || v3_r;
  assign gathering   = (state_r == B_GATHER);
  assign acc_addr    = ADDR_W'(t_r) * ADDR_W'(N_ENTRIES) + ADDR_W'(e_r);
  assign gather_addr = ADDR_W'(k_r) * ADDR_W'(N_ENTRIES) + ADDR_W'(g_r);
  assign rd_addr     = gathering ? gather_addr : a1_r;

  assign w_full  = item_r.f1[weight_a(t_r)] * item_r.f1[weight_b(t_r)];
  assign fe_full = item_r.f2[entry_row(e_r)] * item_r.f2[entry_col(e_r)];
  assign p_full  = w1_r * fe1_r;

  always_comb begin
    sum_wide = (SUM_WIDTH+1)'(acc3_r) + (SUM_WIDTH+1)'(c3_r);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (!q_empty) state_nxt = B_ACC;
      B_ACC:    if (acc_last) state_nxt = B_DRAIN;
      B_DRAIN:  if (!pipe_busy) state_nxt = item_r.final_pair ? B_GATHER : B_IDLE;
      B_GATHER: if (g_r == IDX_W'(N_ENTRIES)) state_nxt = B_SHOW;
      B_SHOW:   if (pop) state_nxt = (k_r == LAST_TERM) ? B_IDLE : B_GATHER;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (state_r == B_IDLE) && !q_empty;
    empty      = (state_r != B_SHOW);
    term_index = k_r;
    final_term = (k_r == LAST_TERM);
    pair_count = PAIR_OUT_W'(pairs_r);
    entry_00   = out_entry_r[0];
    entry_01   = out_entry_r[1];
    entry_02   = out_entry_r[2];
    entry_11   = out_entry_r[3];
    entry_12   = out_entry_r[4];
    entry_22   = out_entry_r[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      t_r     <= '0;
      e_r     <= '0;
      k_r     <= '0;
      g_r     <= '0;
      pairs_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= acc_step;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (q_pop) begin
        t_r <= '0;
        e_r <= '0;
        if (pairs_r < COUNT_W'(MAX_PAIRS)) pairs_r <= pairs_r + COUNT_W'(1);
      end else if (acc_step) begin
        if (e_r == LAST_ENTRY) begin
          e_r <= '0;
          t_r <= t_r + IDX_W'(1);
        end else begin
          e_r <= e_r + IDX_W'(1);
        end
      end
      if (v3_r) valid_r[a3_r] <= 1'b1;
      if (gathering) begin
        g_r <= g_r + IDX_W'(1);
      end else begin
        g_r <= '0;
      end
      if ((state_r == B_SHOW) && pop) begin
        if (k_r == LAST_TERM) begin
          k_r     <= '0;
          pairs_r <= '0;
          valid_r <= '0;
        end else begin
          k_r <= k_r + IDX_W'(1);
        end
      end
    end
  end

  // Datapath and sum memory; an entry whose valid bit is clear reads as zero.
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
    w1_r   <= w_full[WEIGHT_W-1:0];
    fe1_r  <= fe_full[WEIGHT_W-1:0];
    a1_r   <= acc_addr;
    p2_r   <= p_full[PROD_W-1:0];
    a2_r   <= a1_r;
    rd_r   <= sum_mem_r[rd_addr];
    rdv_r  <= valid_r[rd_addr];
    c3_r   <= round30(p2_r);
    acc3_r <= rdv_r ? rd_r : '0;
    a3_r   <= a2_r;
    if (v3_r) sum_mem_r[a3_r] <= sum_sat;
    if (gathering && (g_r != '0)) begin
      out_entry_r[g_r - IDX_W'(1)] <= rdv_r ? ENTRY_W'(rd_r) : '0;
    end
  end

  `BPMA_ASSERT_IMP(a_idle_pipe_empty, state_r == B_IDLE, !pipe_busy, "accumulate pipeline busy while idle")
  `BPMA_ASSERT_IMP(a_write_in_acc, v3_r, (state_r == B_ACC) || (state_r == B_DRAIN), "sum write outside accumulation")
  `BPMA_ASSERT_NXT(a_clear_after_last, (state_r == B_SHOW) && pop && (k_r == LAST_TERM), (valid_r == '0) && (pairs_r == '0), "sums not cleared after the last term")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for bearing_pair_moment_accumulator_core: random pair sets
// checked against a bit-exact moment predictor. Depends on bpma_pkg and the core RTL.
module testbench;
  import bpma_pkg::*;

  localparam int LIMIT = 3000000;

  typedef struct {
    logic [IDX_W-1:0]      term;
    logic [ENTRY_W-1:0]    entry [6];
    logic [PAIR_OUT_W-1:0] count;
    logic                  last;
  } moment_t;

  class moment_board;
    longint  sums [6][6];
    int      pairs;
    moment_t pending [$];
    int      errors;

    function new();
      foreach (sums[t, e]) sums[t][e] = 0;
      pairs  = 0;
      errors = 0;
    endfunction

    static function longint unsigned int_root(longint unsigned v);
      longint unsigned r, bitv;
      r    = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      return r;
    endfunction

    // Unit bearing (x, y, 1)/length in Q1.15, rounded half away from zero.
    static function void bearing(input longint x, input longint y, output longint f [3]);
      longint          c [3];
      longint unsigned len, mag, q;
      c[0] = x;
      c[1] = y;
      c[2] = Z_COMPONENT;
      len  = int_root((longint'(x * x + y * y) + (64'd1 << 24)) << 24);
      for (int i = 0; i < 3; i++) begin
        mag = c[i] < 0 ? -c[i] : c[i];
        q   = ((mag << 27) + (len >> 1)) / len;
        if (q > BEAR_ONE) q = BEAR_ONE;
        f[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
    endfunction

    static function longint to_q30(longint p);
      longint unsigned mag;
      mag = p < 0 ? -p : p;
      mag = (mag + (64'd1 << 29)) >> 30;
      return p < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function void note_pair(logic signed [15:0] rx, logic signed [15:0] ry,
                            logic signed [15:0] cx, logic signed [15:0] cy, logic fin);
      longint  f1 [3], f2 [3], w, c, hi, lo;
      int      ra [6] = '{0, 1, 2, 0, 1, 2};
      int      rb [6] = '{0, 1, 2, 1, 2, 0};
      int      er [6] = '{0, 0, 0, 1, 1, 2};
      int      ec [6] = '{0, 1, 2, 1, 2, 2};
      moment_t m;
      hi = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
      lo = -hi - 1;
      bearing(rx, ry, f1);
      bearing(cx, cy, f2);
      for (int t = 0; t < 6; t++) begin
        w = f1[ra[t]] * f1[rb[t]];
        for (int e = 0; e < 6; e++) begin
          c = to_q30(w * (f2[er[e]] * f2[ec[e]]));
          if (c > 0 && sums[t][e] > hi - c) sums[t][e] = hi;
          else if (c < 0 && sums[t][e] < lo - c) sums[t][e] = lo;
          else sums[t][e] += c;
        end
      end
      if (pairs < MAX_PAIRS) pairs++;
      if (!fin) return;
      for (int t = 0; t < 6; t++) begin
        m.term = IDX_W'(t);
        for (int e = 0; e < 6; e++) m.entry[e] = sums[t][e][ENTRY_W-1:0];
        m.count = pairs[PAIR_OUT_W-1:0];
        m.last  = (t == 5);
        pending.push_back(m);
      end
      foreach (sums[t, e]) sums[t][e] = 0;
      pairs = 0;
    endfunction

    function void check(moment_t got);
      moment_t want;
      string   names [6] = '{"entry_00", "entry_01", "entry_02",
                             "entry_11", "entry_12", "entry_22"};
      if (pending.size() == 0) begin
        $error("unexpected result transaction, term_index %0d", got.term);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.term !== want.term) begin
        $error("term_index: expected %0d, actual %0d", want.term, got.term);
        errors++;
      end
      for (int e = 0; e < 6; e++)
        if (got.entry[e] !== want.entry[e]) begin
          $error("%s: expected %h, actual %h", names[e], want.entry[e], got.entry[e]);
          errors++;
        end
      if (got.count !== want.count) begin
        $error("pair_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("final_term: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [COORD_W-1:0] in_ref_x = '0, in_ref_y = '0, in_cur_x = '0, in_cur_y = '0;
  logic in_final_pair = 1'b0;
  logic [IDX_W-1:0] out_term_index;
  logic signed [ENTRY_W-1:0] out_entry_00, out_entry_01, out_entry_02;
  logic signed [ENTRY_W-1:0] out_entry_11, out_entry_12, out_entry_22;
  logic [PAIR_OUT_W-1:0] out_pair_count;
  logic out_final_term;
  int unsigned cycle_count = 0;
  moment_board board = new();

  bearing_pair_moment_accumulator_core u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_pair(input logic signed [15:0] rx, ry, cx, cy, input logic fin);
    int gap;
    gap = $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ref_x      <= rx;
    in_ref_y      <= ry;
    in_cur_x      <= cx;
    in_cur_y      <= cy;
    in_final_pair <= fin;
    push          <= 1'b1;
    do @(posedge clk); while (full);
    board.note_pair(rx, ry, cx, cy, fin);
  endtask

  // Mostly small coordinates like real normalized points, now and then the full range.
  function automatic logic signed [15:0] pick_coord();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
  endfunction

  task automatic send_random_set(input int len);
    for (int i = 0; i < len; i++)
      send_pair(pick_coord(), pick_coord(), pick_coord(), pick_coord(), i == len - 1);
  endtask

  // Result side: random pop stalls, each transaction checked as it is taken.
  initial begin
    moment_t got;
    int gap;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.term     = out_term_index;
      got.entry[0] = out_entry_00;
      got.entry[1] = out_entry_01;
      got.entry[2] = out_entry_02;
      got.entry[3] = out_entry_11;
      got.entry[4] = out_entry_12;
      got.entry[5] = out_entry_22;
      got.count    = out_pair_count;
      got.last     = out_final_term;
      board.check(got);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: coordinate extremes, origin, single-pair sets and short sets.
    send_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    send_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh1000, 16'shf000, 16'sh0001, 16'shffff, 1'b0);
    send_pair(16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0000, 1'b1);
    send_pair(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 1'b0);
    send_pair(16'shffff, 16'sh0001, 16'sh7fff, 16'sh0000, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);

    // Random sets of mixed length; one pause lets the result side drain fully.
    for (int n = 0; n < 490;) begin
      int len;
      len = $urandom_range(1, 12);
      send_random_set(len);
      n += len;
      if (n > 240 && n <= 240 + len) begin
        push <= 1'b0;
        wait (board.pending.size() == 0);
        @(posedge clk);
      end
    end
    push <= 1'b0;

    wait (board.pending.size() == 0);
    repeat (500) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hdl
hdl/bpma_pkg.sv
hdl/bpma_lift.sv
hdl/bpma_front.sv
hdl/bpma_queue.sv
hdl/bpma_back.sv
hdl/bearing_pair_moment_accumulator_core.sv
tb/testbench.sv
